[rtl/core/tdr_pkg.sv]
// Package for the TCP destination rewrite block: shared constants, the
// controller/datapath command and status structs, and one's-complement add.
// No dependencies.
package tdr_pkg;

  localparam int unsigned LEN_W = 16;

  localparam logic [31:0] DEST_RESET = 32'h80705D6A;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  localparam int unsigned IP_MIN_HDR   = 20;
  localparam int unsigned OFS_TOTAL_HI = 2;
  localparam int unsigned OFS_TOTAL_LO = 3;
  localparam int unsigned OFS_PROTO    = 9;
  localparam int unsigned OFS_HCHK_HI  = 10;
  localparam int unsigned OFS_HCHK_LO  = 11;
  localparam int unsigned OFS_SRC      = 12;
  localparam int unsigned OFS_DST      = 16;
  localparam int unsigned OFS_DST_END  = 19;
  localparam int unsigned TCP_CHK_OFS  = 16;
  localparam int unsigned TCP_MIN_SEG  = 18;

  localparam logic [2:0] HDR_WR_LAST  = 3'd6;
  localparam logic [2:0] SEG_ADD_LAST = 3'd1;
  localparam logic [2:0] SEG_WR_LAST  = 3'd1;

  typedef struct packed {
    logic       load;
    logic       pull;
    logic       fin_start;
    logic       sweep;
    logic       hdr_wr;
    logic       seg_add;
    logic       seg_wr;
    logic [2:0] step;
  } tdr_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic hdr_fits;
    logic seg_ok;
  } tdr_sts_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + 16'(s[16]);
  endfunction

endpackage

[rtl/core/tcp_dest_rewrite_checksum.sv]
// Top level: IPv4/TCP destination rewrite with checksum recompute.
// Load beat: one byte while idle. The final load beat starts a finishing pass that
// holds busy over N stored bytes (one store read per cycle, data registered), then
// 7 header writes if the header fits and, when a TCP checksum is written, 2 sum steps
// and 2 byte writes. Pull beat: one per cycle while idle; result next cycle.
// Synchronous active-low reset clears control state; store contents stay undefined.
module tcp_dest_rewrite_checksum
  import tdr_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_in,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_overflow_flag
);

  tdr_cmd_t cmd;
  tdr_sts_t sts;

  tdr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .in_last_in  (in_last_in),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  tdr_dp #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_last_in        (in_last_in),
    .in_data_byte      (in_data_byte),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .out_overflow_flag (out_overflow_flag)
  );

endmodule

[rtl/core/tdr_ctrl.sv]
// Controller for the TCP destination rewrite block: accepts beats, sequences
// the finishing sweep, header writes and TCP checksum steps.
// Depends on tdr_pkg.
module tdr_ctrl
  import tdr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_req_type,
  input  logic     in_last_in,
  input  tdr_sts_t sts,
  output tdr_cmd_t cmd,
  output logic     busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SWEEP   = 3'd1;
  localparam logic [2:0] S_HDR_WR  = 3'd2;
  localparam logic [2:0] S_SEG_ADD = 3'd3;
  localparam logic [2:0] S_SEG_WR  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load      = start && !in_req_type;
        cmd.pull      = start && in_req_type;
        cmd.fin_start = start && !in_req_type && in_last_in;
        if (cmd.fin_start) begin
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          step_nxt  = '0;
          state_nxt = sts.hdr_fits ? S_HDR_WR : S_IDLE;
        end
      end
      S_HDR_WR: begin
        cmd.hdr_wr = 1'b1;
        if (step_r == HDR_WR_LAST) begin
          step_nxt  = '0;
          state_nxt = sts.seg_ok ? S_SEG_ADD : S_IDLE;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_SEG_ADD: begin
        cmd.seg_add = 1'b1;
        if (step_r == SEG_ADD_LAST) begin
          step_nxt  = '0;
          state_nxt = S_SEG_WR;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_SEG_WR: begin
        cmd.seg_wr = 1'b1;
        if (step_r == SEG_WR_LAST) begin
          step_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      default: begin
        step_nxt  = '0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/core/tdr_dp.sv]
// Datapath for the TCP destination rewrite block: packet store, counters,
// checksum accumulators, destination register and result registers.
// Depends on tdr_pkg; driven by tdr_ctrl commands.
module tdr_dp
  import tdr_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tdr_cmd_t    cmd,
  input  logic        in_last_in,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output tdr_sts_t    sts,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_overflow_flag
);

  localparam int unsigned AW = $clog2(MAX_PACKET);
  localparam int unsigned CW = $clog2(MAX_PACKET + 1);

  function automatic logic [7:0] dest_byte(input logic [31:0] d, input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = d[31:24];
      2'd1:    b = d[23:16];
      2'd2:    b = d[15:8];
      default: b = d[7:0];
    endcase
    return b;
  endfunction

  logic [7:0]    mem [MAX_PACKET];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  logic [31:0]      dest_r, dest_nxt;
  logic [CW-1:0]    wc_r, wc_nxt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             ready_r, ready_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic             dvalid_r, dvalid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [AW-1:0]    dptr_r, dptr_nxt;
  logic [5:0]       hl_r, hl_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic [15:0]      hdr_acc_r, hdr_acc_nxt;
  logic [15:0]      seg_acc_r, seg_acc_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic [CW-1:0]    eff_wc;
  logic             full;
  logic             can_pull;
  logic             issue;
  logic [LEN_W-1:0] wc_len, dptr_len, hl_len, seg_end, seg_len;
  logic [7:0]       hv, seg_b;
  logic [15:0]      hdr_word, seg_word;
  logic             hdr_in, src_in, seg_in;
  logic [AW-1:0]    seg_off, hl_a;
  logic [15:0]      hdr_chk, seg_chk;

  assign eff_wc   = ready_r ? '0 : wc_r;
  assign full     = (eff_wc == CW'(MAX_PACKET));
  assign can_pull = ready_r && (rd_idx_r < wc_r);
  assign issue    = cmd.sweep && (ptr_r < wc_r);

  assign wc_len   = LEN_W'(wc_r);
  assign dptr_len = LEN_W'(dptr_r);
  assign hl_len   = LEN_W'(hl_r);
  assign hl_a     = AW'(hl_r);
  assign seg_end  = (total_r < wc_len) ? total_r : wc_len;
  assign seg_len  = (seg_end > hl_len) ? (seg_end - hl_len) : '0;

  assign sts.sweep_done = (ptr_r == wc_r) && !dvalid_r;
  assign sts.hdr_fits   = (wc_len >= hl_len);
  assign sts.seg_ok     = (seg_len >= LEN_W'(TCP_MIN_SEG));

  // header byte as rewritten, check field taken as zero
  always_comb begin
    if (dptr_r == AW'(OFS_PROTO)) begin
      hv = PROTO_TCP;
    end else if (dptr_r == AW'(OFS_HCHK_HI) || dptr_r == AW'(OFS_HCHK_LO)) begin
      hv = 8'h00;
    end else if (dptr_r >= AW'(OFS_DST) && dptr_r <= AW'(OFS_DST_END)) begin
      hv = dest_byte(dest_r, dptr_r[1:0]);
    end else begin
      hv = rd_data_r;
    end
  end

  assign seg_off  = dptr_r - hl_a;
  assign seg_b    = (seg_off == AW'(TCP_CHK_OFS) || seg_off == AW'(TCP_CHK_OFS + 1)) ?
                    8'h00 : rd_data_r;
  assign hdr_word = dptr_r[0] ? {8'h00, hv} : {hv, 8'h00};
  assign seg_word = dptr_r[0] ? {8'h00, seg_b} : {seg_b, 8'h00};
  assign hdr_in   = (dptr_r == '0) || (dptr_r < hl_a);
  assign src_in   = (dptr_r >= AW'(OFS_SRC)) && (dptr_r <= AW'(OFS_DST_END));
  assign seg_in   = (dptr_r >= hl_a) && (dptr_len < total_r);
  assign hdr_chk  = ~hdr_acc_r;
  assign seg_chk  = ~seg_acc_r;

  assign mem_raddr = cmd.sweep ? ptr_r[AW-1:0] : rd_idx_r[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = eff_wc[AW-1:0];
    mem_wdata = in_data_byte;
    if (cmd.load && !full) begin
      mem_we = 1'b1;
    end
    if (cmd.hdr_wr) begin
      mem_we = 1'b1;
      case (cmd.step) inside
        3'd0: begin
          mem_waddr = AW'(OFS_PROTO);
          mem_wdata = PROTO_TCP;
        end
        [3'd1:3'd4]: begin
          mem_waddr = AW'(OFS_DST) + AW'(cmd.step - 3'd1);
          mem_wdata = dest_byte(dest_r, 2'(cmd.step - 3'd1));
        end
        3'd5: begin
          mem_waddr = AW'(OFS_HCHK_HI);
          mem_wdata = hdr_chk[15:8];
        end
        default: begin
          mem_waddr = AW'(OFS_HCHK_LO);
          mem_wdata = hdr_chk[7:0];
        end
      endcase
    end
    if (cmd.seg_wr) begin
      mem_we = 1'b1;
      if (cmd.step == '0) begin
        mem_waddr = hl_a + AW'(TCP_CHK_OFS);
        mem_wdata = seg_chk[15:8];
      end else begin
        mem_waddr = hl_a + AW'(TCP_CHK_OFS + 1);
        mem_wdata = seg_chk[7:0];
      end
    end
  end

  always_comb begin
    dest_nxt      = cfg_wr_en ? cfg_wr_data : dest_r;
    wc_nxt        = wc_r;
    rd_idx_nxt    = rd_idx_r;
    ready_nxt     = ready_r;
    ovf_nxt       = ovf_r;
    ptr_nxt       = ptr_r;
    dvalid_nxt    = issue;
    dptr_nxt      = dptr_r;
    hl_nxt        = hl_r;
    total_nxt     = total_r;
    hdr_acc_nxt   = hdr_acc_r;
    seg_acc_nxt   = seg_acc_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (cmd.load) begin
      wc_nxt     = full ? eff_wc : eff_wc + CW'(1);
      ovf_nxt    = (ready_r ? 1'b0 : ovf_r) | full;
      ready_nxt  = in_last_in;
      rd_idx_nxt = '0;
    end

    if (cmd.fin_start) begin
      ptr_nxt     = '0;
      dvalid_nxt  = 1'b0;
      hl_nxt      = 6'(IP_MIN_HDR);
      total_nxt   = '0;
      hdr_acc_nxt = '0;
      seg_acc_nxt = '0;
    end

    if (cmd.pull && can_pull) begin
      rd_idx_nxt    = rd_idx_r + CW'(1);
      out_valid_nxt = 1'b1;
      out_last_nxt  = (rd_idx_r + CW'(1) == wc_r);
      out_ovf_nxt   = ovf_r;
    end

    if (issue) begin
      ptr_nxt  = ptr_r + CW'(1);
      dptr_nxt = ptr_r[AW-1:0];
    end

    if (dvalid_r) begin
      if (dptr_r == '0) begin
        hl_nxt = (rd_data_r[3:0] < 4'd5) ? 6'(IP_MIN_HDR) : {rd_data_r[3:0], 2'b00};
      end
      if (dptr_r == AW'(OFS_TOTAL_HI)) begin
        total_nxt[15:8] = rd_data_r;
      end
      if (dptr_r == AW'(OFS_TOTAL_LO)) begin
        total_nxt[7:0] = rd_data_r;
      end
      if (hdr_in) begin
        hdr_acc_nxt = oc_add(hdr_acc_r, hdr_word);
      end
      if (src_in) begin
        seg_acc_nxt = oc_add(seg_acc_r, hdr_word);
      end else if (seg_in) begin
        seg_acc_nxt = oc_add(seg_acc_r, seg_word);
      end
    end

    if (cmd.seg_add) begin
      seg_acc_nxt = oc_add(seg_acc_r, (cmd.step == '0) ? 16'(PROTO_TCP) : seg_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r      <= DEST_RESET;
      wc_r        <= '0;
      rd_idx_r    <= '0;
      ready_r     <= 1'b0;
      ovf_r       <= 1'b0;
      ptr_r       <= '0;
      dvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dest_r      <= dest_nxt;
      wc_r        <= wc_nxt;
      rd_idx_r    <= rd_idx_nxt;
      ready_r     <= ready_nxt;
      ovf_r       <= ovf_nxt;
      ptr_r       <= ptr_nxt;
      dvalid_r    <= dvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dptr_r     <= dptr_nxt;
    hl_r       <= hl_nxt;
    total_r    <= total_nxt;
    hdr_acc_r  <= hdr_acc_nxt;
    seg_acc_r  <= seg_acc_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = rd_data_r;
  assign out_last          = out_last_r;
  assign out_overflow_flag = out_ovf_r;

endmodule

[rtl/core/tdr_chk.sv]
// Port-level checker for tcp_dest_rewrite_checksum, bound to the top level.
// No package dependencies.
module tdr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_req_type,
  input logic        in_last_in,
  input logic        out_valid,
  input logic        out_last
);

  a_result_needs_pull: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_req_type))
    else $error("result beat without a pull beat");

  a_last_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_req_type && in_last_in) |=> busy)
    else $error("final load beat did not start the finishing pass");

  a_plain_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_req_type && !in_last_in) |=> !busy)
    else $error("busy after a non-final load beat");

  a_nothing_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result beat after the final byte");

endmodule

bind tcp_dest_rewrite_checksum tdr_chk u_chk (.*);
